### rtl/core/vaps_pkg.sv
// ----------------------------------------------------------------------------
// vaps_pkg
// Shared types, widths and register indexes of the voice activity packet
// source.
// ----------------------------------------------------------------------------
`default_nettype none

package vaps_pkg;

    // field widths
    localparam int unsigned PROB_W     = 17;
    localparam int unsigned DRAW_W     = 16;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned JIT_W      = 21;
    localparam int unsigned US_W       = 20;
    localparam int unsigned TICKS_W    = 8;
    localparam int unsigned BYTES_W    = 16;
    localparam int unsigned DELAY_W    = 28;
    localparam int unsigned OFFSET_W   = 21;
    localparam int unsigned HOLD_W     = 26;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 88;

    localparam logic [HOLD_W-1:0]  US_PER_MS = HOLD_W'(1000);
    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TALK_TO_SIL_PROB  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIL_TO_TALK_PROB  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_INTERVAL_US = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIL_FRAME_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_BOUND_US   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TALK_PAYLOAD      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIL_PAYLOAD       = 3'd6;

    typedef struct packed {
        logic [PROB_W-1:0]  talk_to_silence_prob;
        logic [PROB_W-1:0]  silence_to_talk_prob;
        logic [US_W-1:0]    voice_interval_us;
        logic [TICKS_W-1:0] silence_frame_ticks;
        logic [US_W-1:0]    jitter_bound_us;
        logic [BYTES_W-1:0] talk_payload_bytes;
        logic [BYTES_W-1:0] silence_payload_bytes;
    } t_cfg;

    typedef struct packed {
        logic signed [JIT_W-1:0] jitter_draw_us;
        logic [MS_W-1:0]         silence_hold_ms;
        logic [MS_W-1:0]         talk_hold_ms;
        logic [DRAW_W-1:0]       uniform_draw;
    } t_tick;

    // one updated tick, before the delay is formed
    typedef struct packed {
        logic                    packet_valid;
        logic [BYTES_W-1:0]      payload_bytes;
        logic [TICKS_W-1:0]      frame_ticks;
        logic [OFFSET_W-1:0]     jitter_offset_us;
        logic signed [JIT_W-1:0] applied_jitter_us;
        logic                    talking;
        logic                    hold_renewed;
        logic [MS_W-1:0]         hold_ms;
    } t_upd;

endpackage

`default_nettype wire

### rtl/core/voice_activity_packet_source.sv
// ----------------------------------------------------------------------------
// voice_activity_packet_source
// Two-state talk/silence on-off source producing one descriptor per tick.
// ----------------------------------------------------------------------------
// Each transfer on the slave stream is one voice-frame tick carrying the
// random draws; each tick yields exactly one transfer on the master stream.
// The master tuser bit is set when the tick closed a frame and the descriptor
// holds a packet (payload size, send delay, applied jitter).
// Registers are written over the cfg channel, which is always ready; write
// them only while no tick is in flight.
// A tick passes three registers to its result: input register, state
// update register, delay register. Throughput is one tick per cycle unless
// the receiver stalls; talk state, hold and frame countdown update per tick.
// Reset (synchronous, active low) returns to silence with an expired hold,
// one tick left in the frame, and all registers at their defaults.
// When the receiver stalls, the result holds and the stages behind it keep
// filling; slave tready drops once all three stages are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_activity_packet_source (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [vaps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [vaps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // tick stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [15:0] uniform_draw, [31:16] talk_hold_ms, [47:32] silence_hold_ms,
    // [68:48] jitter_draw_us, [71:69] zero
    input  wire logic [vaps_pkg::S_DATA_W-1:0]    i_s_tdata,
    // descriptor stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [15:0] payload_bytes, [43:16] send_delay_us, [64:44] applied_jitter_us,
    // [65] talking, [66] hold_renewed, [82:67] hold_ms, [87:83] zero
    output logic [vaps_pkg::M_DATA_W-1:0]         o_m_tdata,
    // [0] packet_valid
    output logic                                  o_m_tuser
);

    vaps_pkg::t_cfg   cfg;
    vaps_pkg::t_tick  tick;
    vaps_pkg::t_upd   upd;
    logic             upd_valid;
    logic             upd_ready;

    assign tick.uniform_draw    = i_s_tdata[15:0];
    assign tick.talk_hold_ms    = i_s_tdata[31:16];
    assign tick.silence_hold_ms = i_s_tdata[47:32];
    assign tick.jitter_draw_us  = i_s_tdata[68:48];

    vaps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vaps_update u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_tick_valid (i_s_tvalid),
        .o_tick_ready (o_s_tready),
        .i_tick       (tick),
        .o_upd_valid  (upd_valid),
        .i_upd_ready  (upd_ready),
        .o_upd        (upd)
    );

    vaps_delay u_delay (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_upd_valid (upd_valid),
        .o_upd_ready (upd_ready),
        .i_upd       (upd),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

### rtl/core/vaps_cfg.sv
// ----------------------------------------------------------------------------
// vaps_cfg
// Configuration register file, written by index through a valid/ready port.
// ----------------------------------------------------------------------------
`default_nettype none

module vaps_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [vaps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [vaps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output vaps_pkg::t_cfg                        o_cfg
);

    vaps_pkg::t_cfg r_cfg;
    vaps_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vaps_pkg::REG_TALK_TO_SIL_PROB: begin
                    n_cfg.talk_to_silence_prob = i_cfg_data[vaps_pkg::PROB_W-1:0];
                end
                vaps_pkg::REG_SIL_TO_TALK_PROB: begin
                    n_cfg.silence_to_talk_prob = i_cfg_data[vaps_pkg::PROB_W-1:0];
                end
                vaps_pkg::REG_VOICE_INTERVAL_US: begin
                    n_cfg.voice_interval_us = i_cfg_data[vaps_pkg::US_W-1:0];
                end
                vaps_pkg::REG_SIL_FRAME_TICKS: begin
                    n_cfg.silence_frame_ticks = i_cfg_data[vaps_pkg::TICKS_W-1:0];
                end
                vaps_pkg::REG_JITTER_BOUND_US: begin
                    n_cfg.jitter_bound_us = i_cfg_data[vaps_pkg::US_W-1:0];
                end
                vaps_pkg::REG_TALK_PAYLOAD: begin
                    n_cfg.talk_payload_bytes = i_cfg_data[vaps_pkg::BYTES_W-1:0];
                end
                vaps_pkg::REG_SIL_PAYLOAD: begin
                    n_cfg.silence_payload_bytes = i_cfg_data[vaps_pkg::BYTES_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.talk_to_silence_prob  <= vaps_pkg::PROB_W'(1049);
            r_cfg.silence_to_talk_prob  <= vaps_pkg::PROB_W'(1049);
            r_cfg.voice_interval_us     <= vaps_pkg::US_W'(20000);
            r_cfg.silence_frame_ticks   <= vaps_pkg::TICKS_W'(8);
            r_cfg.jitter_bound_us       <= vaps_pkg::US_W'(80000);
            r_cfg.talk_payload_bytes    <= vaps_pkg::BYTES_W'(33);
            r_cfg.silence_payload_bytes <= vaps_pkg::BYTES_W'(7);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### rtl/core/vaps_update.sv
// ----------------------------------------------------------------------------
// vaps_update
// Input register and per-tick state update: hold and frame countdown,
// Markov transition test, hold renewal, payload and jitter selection.
// ----------------------------------------------------------------------------
`default_nettype none

module vaps_update (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire vaps_pkg::t_cfg  i_cfg,
    input  wire logic            i_tick_valid,
    output logic                 o_tick_ready,
    input  wire vaps_pkg::t_tick i_tick,
    output logic                 o_upd_valid,
    input  wire logic            i_upd_ready,
    output vaps_pkg::t_upd       o_upd
);

    localparam int unsigned SUM_W = vaps_pkg::PROB_W + 1;
    localparam int unsigned BND_W = vaps_pkg::JIT_W + 1;

    // input register
    logic                r_in_valid;
    vaps_pkg::t_tick     r_in;

    // source state
    logic                              r_talking;
    logic [vaps_pkg::HOLD_W-1:0]       r_hold_us;
    logic [vaps_pkg::TICKS_W-1:0]      r_frame_left;
    logic                              r_pending;

    // update register
    logic                r_upd_valid;
    vaps_pkg::t_upd      r_upd;

    logic                              upd_ready;
    logic                              advance;
    logic [vaps_pkg::HOLD_W-1:0]       interval_ext;
    logic [vaps_pkg::HOLD_W-1:0]       hold_dec;
    logic [vaps_pkg::TICKS_W-1:0]      frame_dec;
    logic [vaps_pkg::PROB_W-1:0]       prob_raw;
    logic [vaps_pkg::PROB_W-1:0]       prob;
    logic [SUM_W-1:0]                  test_sum;
    logic                              flip;
    logic                              renew;
    logic                              boundary;
    logic                              n_talking;
    logic [vaps_pkg::MS_W-1:0]         new_ms;
    logic [vaps_pkg::HOLD_W-1:0]       n_hold_us;
    logic [vaps_pkg::TICKS_W-1:0]      sil_ticks;
    logic [vaps_pkg::TICKS_W-1:0]      ticks;
    logic [vaps_pkg::TICKS_W-1:0]      n_frame_left;
    logic                              n_pending;
    logic signed [BND_W-1:0]           bound;
    logic signed [BND_W-1:0]           draw;
    logic signed [BND_W-1:0]           clamped;
    logic signed [BND_W-1:0]           offset;
    vaps_pkg::t_upd                    n_upd;

    assign upd_ready    = !r_upd_valid || i_upd_ready;
    assign advance      = r_in_valid && upd_ready;
    assign o_tick_ready = !r_in_valid || upd_ready;
    assign o_upd_valid  = r_upd_valid;
    assign o_upd        = r_upd;

    always_comb begin
        interval_ext = vaps_pkg::HOLD_W'(i_cfg.voice_interval_us);
        hold_dec     = (r_hold_us > interval_ext) ? (r_hold_us - interval_ext) : '0;
        frame_dec    = (r_frame_left != '0) ? (r_frame_left - 1'b1) : '0;

        // probability above one acts as one
        prob_raw = r_talking ? i_cfg.talk_to_silence_prob : i_cfg.silence_to_talk_prob;
        prob     = prob_raw[vaps_pkg::PROB_W-1]
                 ? {1'b1, {(vaps_pkg::PROB_W-1){1'b0}}} : prob_raw;
        test_sum = SUM_W'(r_in.uniform_draw) + SUM_W'(prob);
        flip     = r_pending || (test_sum[SUM_W-1:SUM_W-2] != 2'b00);

        boundary  = (frame_dec == '0);
        renew     = (hold_dec == '0) && boundary;
        n_talking = renew ? (r_talking ^ flip) : r_talking;
        new_ms    = n_talking ? r_in.talk_hold_ms : r_in.silence_hold_ms;
        n_hold_us = renew ? (vaps_pkg::HOLD_W'(new_ms) * vaps_pkg::US_PER_MS) : hold_dec;
        n_pending = renew ? 1'b0 : flip;

        sil_ticks    = (i_cfg.silence_frame_ticks == '0)
                     ? vaps_pkg::TICKS_W'(1) : i_cfg.silence_frame_ticks;
        ticks        = n_talking ? vaps_pkg::TICKS_W'(1) : sil_ticks;
        n_frame_left = boundary ? ticks : frame_dec;

        // clamp jitter to plus or minus the bound
        bound = BND_W'(i_cfg.jitter_bound_us);
        draw  = BND_W'(r_in.jitter_draw_us);
        if (i_cfg.jitter_bound_us == '0) begin
            clamped = '0;
        end else if (draw > bound) begin
            clamped = bound;
        end else if (draw < -bound) begin
            clamped = -bound;
        end else begin
            clamped = draw;
        end
        offset = (i_cfg.jitter_bound_us == '0) ? '0 : (clamped + bound);

        n_upd.packet_valid      = boundary;
        n_upd.payload_bytes     = !boundary ? '0
                                : (n_talking ? i_cfg.talk_payload_bytes
                                             : i_cfg.silence_payload_bytes);
        n_upd.frame_ticks       = boundary ? ticks : '0;
        n_upd.jitter_offset_us  = boundary ? offset[vaps_pkg::OFFSET_W-1:0] : '0;
        n_upd.applied_jitter_us = boundary ? clamped[vaps_pkg::JIT_W-1:0] : '0;
        n_upd.talking           = n_talking;
        n_upd.hold_renewed      = renew;
        n_upd.hold_ms           = renew ? new_ms : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_upd_valid  <= 1'b0;
            r_talking    <= 1'b0;
            r_hold_us    <= '0;
            r_frame_left <= vaps_pkg::TICKS_W'(1);
            r_pending    <= 1'b0;
        end else begin
            if (o_tick_ready) begin
                r_in_valid <= i_tick_valid;
            end
            if (upd_ready) begin
                r_upd_valid <= r_in_valid;
            end
            if (advance) begin
                r_talking    <= n_talking;
                r_hold_us    <= n_hold_us;
                r_frame_left <= n_frame_left;
                r_pending    <= n_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tick_ready && i_tick_valid) begin
            r_in <= i_tick;
        end
        if (advance) begin
            r_upd <= n_upd;
        end
    end

    // a frame countdown of zero never survives a tick
    a_frame_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_left != '0)
        else $error("frame countdown left at zero");

    // while talking every tick is a frame boundary
    a_talking_single_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_talking |-> (r_frame_left == vaps_pkg::TICKS_W'(1)))
        else $error("talking frame longer than one tick");

    // a renewal happens only at a frame boundary and clears the pending flip
    a_renew_at_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && renew) |=> (r_upd.packet_valid && !r_pending))
        else $error("hold renewed off a frame boundary");

endmodule

`default_nettype wire

### rtl/core/vaps_delay.sv
// ----------------------------------------------------------------------------
// vaps_delay
// Result register: forms the saturated send delay and packs the descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module vaps_delay (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire vaps_pkg::t_cfg                 i_cfg,
    input  wire logic                           i_upd_valid,
    output logic                                o_upd_ready,
    input  wire vaps_pkg::t_upd                 i_upd,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [vaps_pkg::M_DATA_W-1:0]       o_m_tdata,
    output logic                                o_m_tuser
);

    localparam int unsigned SUM_W = vaps_pkg::DELAY_W + 1;

    logic                                r_valid;
    vaps_pkg::t_upd                      r_upd;
    logic [vaps_pkg::DELAY_W-1:0]        r_delay;

    logic [vaps_pkg::DELAY_W-1:0]        frame_us;
    logic [SUM_W-1:0]                    delay_sum;
    logic [vaps_pkg::DELAY_W-1:0]        n_delay;

    assign o_upd_ready = !r_valid || i_m_tready;

    always_comb begin
        // frame duration fits 28 bits: 255 ticks of at most 2^20 - 1 us
        frame_us  = vaps_pkg::DELAY_W'(i_upd.frame_ticks)
                  * vaps_pkg::DELAY_W'(i_cfg.voice_interval_us);
        delay_sum = SUM_W'(frame_us) + SUM_W'(i_upd.jitter_offset_us);
        n_delay   = delay_sum[SUM_W-1] ? vaps_pkg::DELAY_MAX
                                       : delay_sum[vaps_pkg::DELAY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_upd_ready) begin
            r_valid <= i_upd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_upd_ready && i_upd_valid) begin
            r_upd   <= i_upd;
            r_delay <= n_delay;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_upd.packet_valid;
    assign o_m_tdata  = {5'b0,
                         r_upd.hold_ms,
                         r_upd.hold_renewed,
                         r_upd.talking,
                         r_upd.applied_jitter_us,
                         r_delay,
                         r_upd.payload_bytes};

    // a tick without a packet carries a zero delay
    a_no_packet_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_upd.packet_valid) |-> (r_delay == '0))
        else $error("delay on a tick without packet");

    // renewal is only reported on a packet
    a_renew_has_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_upd.hold_renewed) |-> r_upd.packet_valid)
        else $error("renewal without packet");

    // talking packets always span one frame tick of delay base
    a_talk_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_upd.packet_valid && r_upd.talking)
            |-> (r_upd.frame_ticks == vaps_pkg::TICKS_W'(1)))
        else $error("talking packet with multi-tick frame");

endmodule

`default_nettype wire

### bench/voice_activity_packet_source_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voice_activity_packet_source_test
// Self-checking bench for the talk/silence packet source.
// ----------------------------------------------------------------------------
// Ticks go in on the slave stream with their random draws. Every descriptor
// that comes out is checked field by field against a tick-level model of the
// talk state, hold countdown, frame countdown and delay arithmetic kept in
// this bench. A short directed section covers the reset values and register
// corners (probability above one, zero interval, zero silence frame, jitter
// off, jitter clamp, delay saturation). Random traffic then runs under six
// register settings with back-pressure on either side, then with none.
// ----------------------------------------------------------------------------

module voice_activity_packet_source_test;
    import vaps_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_TICKS = 1230;
    localparam int NUM_PHASES   = 6;
    localparam int MAX_REPORTS  = 10;
    localparam longint Q16_ONE  = 65536;

    typedef struct packed {
        logic                    packet_valid;
        logic [BYTES_W-1:0]      payload_bytes;
        logic [DELAY_W-1:0]      send_delay_us;
        logic signed [JIT_W-1:0] applied_jitter_us;
        logic                    talking;
        logic                    hold_renewed;
        logic [MS_W-1:0]         hold_ms;
    } descriptor_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;

    // model of the source, advanced once per accepted tick
    t_cfg   regs_now;
    logic   talk_now     = 1'b0;
    longint hold_left_us = 0;
    int     frame_left   = 1;
    logic   flip_pend    = 1'b0;

    descriptor_t pending_descriptors[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          quiet_cycles  = 0;
    int          error_count   = 0;
    int          ticks_sent    = 0;
    int          settings_used = 0;
    int          packets_seen  = 0;
    int          renewals_seen = 0;
    int          saturated_seen = 0;
    int          flips_seen    = 0;
    logic        last_talking  = 1'b0;

    voice_activity_packet_source u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic descriptor_t advance_source(input t_tick t);
        descriptor_t d;
        longint ival, prob, ticks, dly, bnd, jit;
        d    = '0;
        jit  = 0;
        ival = regs_now.voice_interval_us;
        hold_left_us = (hold_left_us > ival) ? hold_left_us - ival : 0;
        if (frame_left != 0) begin
            frame_left--;
        end
        prob = talk_now ? regs_now.talk_to_silence_prob : regs_now.silence_to_talk_prob;
        if (prob > Q16_ONE) begin
            prob = Q16_ONE;
        end
        if (longint'(t.uniform_draw) + prob >= Q16_ONE) begin
            flip_pend = 1'b1;
        end
        // the state only moves when hold and frame run out together
        if (hold_left_us == 0 && frame_left == 0) begin
            if (flip_pend) begin
                talk_now = ~talk_now;
            end
            d.hold_ms      = talk_now ? t.talk_hold_ms : t.silence_hold_ms;
            hold_left_us   = longint'(d.hold_ms) * 1000;
            d.hold_renewed = 1'b1;
            flip_pend      = 1'b0;
        end
        if (frame_left == 0) begin
            if (talk_now) begin
                ticks = 1;
            end else begin
                ticks = (regs_now.silence_frame_ticks == 0) ? 1 : regs_now.silence_frame_ticks;
            end
            frame_left = int'(ticks);
            dly = ticks * ival;
            bnd = regs_now.jitter_bound_us;
            if (bnd != 0) begin
                jit = t.jitter_draw_us;
                if (jit > bnd) begin
                    jit = bnd;
                end
                if (jit < -bnd) begin
                    jit = -bnd;
                end
                dly += jit + bnd;
            end
            if (dly > longint'(DELAY_MAX)) begin
                dly = longint'(DELAY_MAX);
            end
            d.packet_valid      = 1'b1;
            d.send_delay_us     = DELAY_W'(dly);
            d.applied_jitter_us = JIT_W'(jit);
            d.payload_bytes     = talk_now ? regs_now.talk_payload_bytes
                                           : regs_now.silence_payload_bytes;
        end
        d.talking = talk_now;
        return d;
    endfunction

    function automatic string describe(input descriptor_t d);
        return $sformatf("pkt=%0b bytes=%0d delay=%0d jitter=%0d talk=%0b renew=%0b hold=%0d",
                         d.packet_valid, d.payload_bytes, d.send_delay_us,
                         d.applied_jitter_us, d.talking, d.hold_renewed, d.hold_ms);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: ready pattern, descriptor check, stall watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin : check_descriptors
        descriptor_t got;
        descriptor_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.packet_valid      = m_tuser;
            got.payload_bytes     = m_tdata[15:0];
            got.send_delay_us     = m_tdata[43:16];
            got.applied_jitter_us = m_tdata[64:44];
            got.talking           = m_tdata[65];
            got.hold_renewed      = m_tdata[66];
            got.hold_ms           = m_tdata[82:67];
            if (pending_descriptors.size() == 0) begin
                if (error_count < MAX_REPORTS) begin
                    $display("%0t: descriptor with no tick outstanding: %s",
                             $realtime, describe(got));
                end
                error_count++;
            end else begin
                want = pending_descriptors.pop_front();
                if (got !== want) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("%0t: descriptor mismatch", $realtime);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                    error_count++;
                end
                packets_seen   += got.packet_valid;
                renewals_seen  += got.hold_renewed;
                saturated_seen += (got.packet_valid && got.send_delay_us == DELAY_MAX);
                flips_seen     += (got.talking != last_talking);
                last_talking    = got.talking;
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("No transfer for %0d cycles, stopping", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic t_tick make_tick(input logic [DRAW_W-1:0] u,
                                        input logic [MS_W-1:0] talk_ms,
                                        input logic [MS_W-1:0] sil_ms,
                                        input int jit);
        t_tick t;
        t.uniform_draw    = u;
        t.talk_hold_ms    = talk_ms;
        t.silence_hold_ms = sil_ms;
        t.jitter_draw_us  = JIT_W'(jit);
        return t;
    endfunction

    function automatic logic [MS_W-1:0] hold_draw(input int unsigned cap_ms,
                                                  input bit wide);
        if (wide && $urandom_range(3) == 0) begin
            return MS_W'($urandom);
        end
        return MS_W'($urandom_range(cap_ms));
    endfunction

    task automatic send_tick(input t_tick t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(t);
        do @(posedge clk); while (!s_tready);
        pending_descriptors.push_back(advance_source(t));
        ticks_sent++;
    endtask

    // hold off the tick stream until every descriptor is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_descriptors.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_config(input t_cfg c);
        drain_results();
        write_register(REG_TALK_TO_SIL_PROB,  CFG_DATA_W'(c.talk_to_silence_prob));
        write_register(REG_SIL_TO_TALK_PROB,  CFG_DATA_W'(c.silence_to_talk_prob));
        write_register(REG_VOICE_INTERVAL_US, CFG_DATA_W'(c.voice_interval_us));
        write_register(REG_SIL_FRAME_TICKS,   CFG_DATA_W'(c.silence_frame_ticks));
        write_register(REG_JITTER_BOUND_US,   CFG_DATA_W'(c.jitter_bound_us));
        write_register(REG_TALK_PAYLOAD,      CFG_DATA_W'(c.talk_payload_bytes));
        write_register(REG_SIL_PAYLOAD,       CFG_DATA_W'(c.silence_payload_bytes));
        cfg_valid <= 1'b0;
        regs_now = c;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset registers: silence frame of 8 ticks, bound 80000, threshold edges
    task automatic test_default_registers();
        send_tick(make_tick(16'd0, 16'd0, 16'd0, 0));
        send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, -1048576));
        send_tick(make_tick(16'd0, 16'd0, 16'd0, 1048575));
        for (int k = 0; k < 4; k++) begin
            send_tick(make_tick(DRAW_W'(64487 - k), 16'd0, 16'd0, 79999 - k));
        end
        send_tick(make_tick(16'd0, 16'd1, 16'd0, 80001));
        send_tick(make_tick(16'd0, 16'd0, 16'd7, -80001));
        send_tick(make_tick(16'd64486, 16'd0, 16'd0, 12345));
    endtask

    // zero interval / zero silence frame / no jitter, then the widest settings
    task automatic test_register_corners();
        t_cfg c;
        c.talk_to_silence_prob  = PROB_W'(65536);
        c.silence_to_talk_prob  = PROB_W'(65536);
        c.voice_interval_us     = '0;
        c.silence_frame_ticks   = '0;
        c.jitter_bound_us       = '0;
        c.talk_payload_bytes    = '0;
        c.silence_payload_bytes = '1;
        apply_config(c);
        send_tick(make_tick(16'd0, 16'd0, 16'd5, 1048575));
        send_tick(make_tick(16'd0, 16'd0, 16'd0, -1));
        send_tick(make_tick(16'd0, 16'd0, 16'd0, -1));

        c.talk_to_silence_prob  = '1;
        c.voice_interval_us     = '1;
        c.silence_frame_ticks   = '1;
        c.jitter_bound_us       = '1;
        c.talk_payload_bytes    = '1;
        c.silence_payload_bytes = '0;
        apply_config(c);
        send_tick(make_tick(16'd0, 16'd0, 16'd0, -1048576));
        // talk to silence with a 255-tick frame pushes the delay past its range
        send_tick(make_tick(16'd0, 16'd0, 16'd0, 1048575));
        send_tick(make_tick(16'd0, 16'd0, 16'd0, 0));
    endtask

    task automatic test_random_traffic();
        t_cfg        c;
        int unsigned per_phase, hold_cap, cap;
        int          bnd, jit;
        bit          wide, wide_now;
        per_phase = RANDOM_TICKS / NUM_PHASES;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            c.talk_to_silence_prob  = PROB_W'($urandom_range(65536));
            c.silence_to_talk_prob  = PROB_W'($urandom_range(65536));
            c.voice_interval_us     = US_W'($urandom_range(40000, 2000));
            c.silence_frame_ticks   = TICKS_W'($urandom_range(12, 1));
            c.jitter_bound_us       = US_W'($urandom_range(100000));
            c.talk_payload_bytes    = BYTES_W'($urandom);
            c.silence_payload_bytes = BYTES_W'($urandom);
            hold_cap = 40;
            wide     = 1'b0;
            case (ph)
                1: begin
                    c.voice_interval_us   = '0;
                    c.silence_frame_ticks = '0;
                    c.jitter_bound_us     = '0;
                    hold_cap              = 0;
                end
                2: begin
                    c.voice_interval_us   = '1;
                    c.jitter_bound_us     = '1;
                    c.silence_frame_ticks = TICKS_W'($urandom_range(4, 1));
                    wide                  = 1'b1;
                end
                3: begin
                    c.talk_to_silence_prob  = '0;
                    c.silence_to_talk_prob  = '1;
                    c.voice_interval_us     = US_W'(1);
                    c.silence_frame_ticks   = TICKS_W'(1);
                    c.jitter_bound_us       = US_W'(1);
                    c.talk_payload_bytes    = '0;
                    c.silence_payload_bytes = '1;
                    hold_cap                = 0;
                end
                4: begin
                    c.talk_to_silence_prob = '1;
                    c.silence_to_talk_prob = PROB_W'(65536);
                end
                default: ;
            endcase
            apply_config(c);
            bnd = int'(c.jitter_bound_us);
            for (int n = 0; n < per_phase; n++) begin
                cap      = hold_cap;
                wide_now = wide;
                // with no countdown a rare short hold freezes the state
                if (ph == 1 && $urandom_range(15) == 0) begin
                    cap = 3;
                end
                // expire every long hold before the 1 us interval setting
                if (wide && per_phase - n <= 70) begin
                    cap      = 0;
                    wide_now = 1'b0;
                end
                case ($urandom_range(3))
                    0: jit = int'($urandom_range(2097151)) - 1048576;
                    1: jit = ($urandom_range(1) ? bnd : -bnd) + int'($urandom_range(2)) - 1;
                    default: jit = int'($urandom_range(2 * bnd)) - bnd;
                endcase
                if (jit > 1048575) begin
                    jit = 1048575;
                end
                if (jit < -1048576) begin
                    jit = -1048576;
                end
                send_tick(make_tick(DRAW_W'($urandom), hold_draw(cap, wide_now),
                                    hold_draw(cap, wide_now), jit));
                if (n % 64 == 63) begin
                    drain_results();
                end
            end
        end
    endtask

    initial begin
        regs_now.talk_to_silence_prob  = PROB_W'(1049);
        regs_now.silence_to_talk_prob  = PROB_W'(1049);
        regs_now.voice_interval_us     = US_W'(20000);
        regs_now.silence_frame_ticks   = TICKS_W'(8);
        regs_now.jitter_bound_us       = US_W'(80000);
        regs_now.talk_payload_bytes    = BYTES_W'(33);
        regs_now.silence_payload_bytes = BYTES_W'(7);
        send_idle_pct = 24;
        recv_idle_pct = 72;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_default_registers();
        test_register_corners();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);

        $display("Checked %0d ticks under %0d register settings plus reset values:",
                 ticks_sent, settings_used);
        $display("%0d packets (%0d with saturated delay), %0d hold renewals, %0d state changes",
                 packets_seen, saturated_seen, renewals_seen, flips_seen);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d descriptor errors", error_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/vaps_pkg.sv
rtl/core/vaps_cfg.sv
rtl/core/vaps_update.sv
rtl/core/vaps_delay.sv
rtl/core/voice_activity_packet_source.sv
bench/voice_activity_packet_source_test.sv
